// ----- rtl/core/pli_pkg.sv -----
package pli_pkg;

	// default list capacity
	localparam int unsigned CAPACITY_DEF = 64;

	// fixed field widths
	localparam int unsigned OP_W     = 1;
	localparam int unsigned POS_W    = 7;
	localparam int unsigned VAL_W    = 8;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned LEN_W    = 7;

	// operation codes
	localparam logic [OP_W-1:0] OP_INSERT = 1'b0;
	localparam logic [OP_W-1:0] OP_DELETE = 1'b1;

	// removed byte when nothing leaves the list
	localparam logic [VAL_W-1:0] NONE_REMOVED = 8'hFF;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_DONE    = 2'd0,
		ST_BAD_POS = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

endpackage

// ----- rtl/core/pli_if.sv -----
// request channel: one list operation per beat
interface pli_req_if;
	logic                         valid;
	logic                         ready;
	logic [pli_pkg::OP_W-1:0]     operation;
	logic [pli_pkg::POS_W-1:0]    position;
	logic [pli_pkg::VAL_W-1:0]    value;

	modport source (output valid, output operation, output position, output value,
		input ready);
	modport sink   (input valid, input operation, input position, input value,
		output ready);
endinterface

// response channel: one result per beat
interface pli_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [pli_pkg::STATUS_W-1:0] status;
	logic [pli_pkg::VAL_W-1:0]    removed;
	logic [pli_pkg::LEN_W-1:0]    length;

	modport source (output valid, output status, output removed, output length,
		input ready);
	modport sink   (input valid, input status, input removed, input length,
		output ready);
endinterface

// ----- rtl/core/positional_list_insert_delete.sv -----
// Positional byte list with insert and delete at a one-based position.
// req channel (valid/ready): operation (insert or delete), position, value.
// rsp channel (valid/ready): status, removed byte, list length afterwards.
// The elements live in a single-port-write, single-port-read memory with a
// registered read port. A valid insert at position p into a list of n
// elements streams n-p+1 elements one slot up, one per cycle, then writes
// the new byte; an insert at the end goes straight to the write, where
// nothing moves. A valid delete reads n-p+1 elements and writes each one
// slot down but the first, whose read yields the removed byte. An invalid
// position or a full list goes straight to the final step. The result is
// loaded into the output register from the final step, and the next beat
// is taken only once it is registered. req.ready is high while no item is
// in work; a finished result waits in the output register, and the next
// item is taken meanwhile. While rsp is stalled a later result holds in
// the final step until the output register frees up.
// Reset empties the list (length 0) and drops any pending result; the
// memory contents are not cleared, as only entries below the length are
// ever read.
module positional_list_insert_delete #(
	parameter int unsigned CAPACITY = pli_pkg::CAPACITY_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	pli_req_if.sink    req,
	pli_rsp_if.source  rsp
);

	localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW   = $clog2(CAPACITY + 1);
	localparam int unsigned CMPW = ((CW > pli_pkg::POS_W) ? CW : pli_pkg::POS_W) + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RUN,
		S_DRAIN,
		S_PUT,
		S_FIN
	} state_t;

	state_t                     state_q;
	logic [CW-1:0]              count_q;
	logic [pli_pkg::OP_W-1:0]   op_q;
	logic [pli_pkg::VAL_W-1:0]  val_q;
	logic [AW-1:0]              pos_m1_q;
	logic [AW-1:0]              stop_q;
	logic [AW-1:0]              rd_addr_q;
	pli_pkg::status_t           res_status_q;
	logic [pli_pkg::VAL_W-1:0]  res_removed_q;

	// read pipeline
	logic                       rvalid_s1;
	logic [AW-1:0]              raddr_s1;
	logic [pli_pkg::VAL_W-1:0]  rdata_s1;

	// output register
	logic                          rsp_valid_q;
	logic [pli_pkg::STATUS_W-1:0]  rsp_status_q;
	logic [pli_pkg::VAL_W-1:0]     rsp_removed_q;
	logic [pli_pkg::LEN_W-1:0]     rsp_length_q;

	logic [pli_pkg::VAL_W-1:0]  slots_q [CAPACITY];

	// request decode
	logic [CMPW-1:0] pos_x;
	logic [CMPW-1:0] cnt_x;
	logic [CMPW-1:0] cnt_new_x;
	logic            ins_bad;
	logic            del_bad;
	logic            full;
	logic            req_fire;
	logic            out_free;
	logic            fin_fire;
	logic            is_gone;

	// memory port controls
	logic                       mem_we;
	logic [AW-1:0]              mem_waddr;
	logic [pli_pkg::VAL_W-1:0]  mem_wdata;
	logic                       mem_re;

	assign req.ready   = (state_q == S_IDLE);
	assign req_fire    = req.valid && (state_q == S_IDLE);
	assign rsp.valid   = rsp_valid_q;
	assign rsp.status  = rsp_status_q;
	assign rsp.removed = rsp_removed_q;
	assign rsp.length  = rsp_length_q;
	assign out_free    = !rsp_valid_q || rsp.ready;
	assign fin_fire    = (state_q == S_FIN) && out_free;

	// position checks against current length
	always_comb begin
		pos_x   = CMPW'(req.position);
		cnt_x   = CMPW'(count_q);
		ins_bad = (pos_x == '0) || (pos_x > cnt_x + CMPW'(1));
		del_bad = (pos_x == '0) || (pos_x > cnt_x);
		full    = (cnt_x >= CMPW'(CAPACITY));
	end

	// length after this item
	always_comb begin
		cnt_new_x = cnt_x;
		if (res_status_q == pli_pkg::ST_DONE) begin
			if (op_q == pli_pkg::OP_INSERT) begin
				cnt_new_x = cnt_x + CMPW'(1);
			end else begin
				cnt_new_x = cnt_x - CMPW'(1);
			end
		end
	end

	// returned read of the deleted slot itself
	assign is_gone = rvalid_s1 && (op_q == pli_pkg::OP_DELETE) && (raddr_s1 == pos_m1_q);

	// write port: shift writeback or new byte
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = raddr_s1;
		mem_wdata = rdata_s1;
		mem_re    = (state_q == S_RUN);
		if (state_q == S_PUT) begin
			mem_we    = 1'b1;
			mem_waddr = pos_m1_q;
			mem_wdata = val_q;
		end else if (rvalid_s1 && !is_gone) begin
			mem_we = 1'b1;
			if (op_q == pli_pkg::OP_INSERT) begin
				mem_waddr = raddr_s1 + AW'(1);
			end else begin
				mem_waddr = raddr_s1 - AW'(1);
			end
		end
	end

	// element memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			slots_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_s1 <= slots_q[rd_addr_q];
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rvalid_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rvalid_s1 <= mem_re;
			raddr_s1  <= rd_addr_q;
			if (fin_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (is_gone) begin
				res_removed_q <= rdata_s1;
			end
			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						op_q          <= req.operation;
						val_q         <= req.value;
						pos_m1_q      <= AW'(pos_x - CMPW'(1));
						res_removed_q <= pli_pkg::NONE_REMOVED;
						res_status_q  <= pli_pkg::ST_DONE;
						if (req.operation == pli_pkg::OP_INSERT) begin
							rd_addr_q <= AW'(cnt_x - CMPW'(1));
							stop_q    <= AW'(pos_x - CMPW'(1));
							if (ins_bad) begin
								res_status_q <= pli_pkg::ST_BAD_POS;
								state_q      <= S_FIN;
							end else if (full) begin
								res_status_q <= pli_pkg::ST_FULL;
								state_q      <= S_FIN;
							end else if (pos_x == cnt_x + CMPW'(1)) begin
								state_q <= S_PUT;
							end else begin
								state_q <= S_RUN;
							end
						end else begin
							rd_addr_q <= AW'(pos_x - CMPW'(1));
							stop_q    <= AW'(cnt_x - CMPW'(1));
							if (del_bad) begin
								res_status_q <= pli_pkg::ST_BAD_POS;
								state_q      <= S_FIN;
							end else begin
								state_q <= S_RUN;
							end
						end
					end
				end
				S_RUN: begin
					if (rd_addr_q == stop_q) begin
						state_q <= S_DRAIN;
					end else if (op_q == pli_pkg::OP_INSERT) begin
						rd_addr_q <= rd_addr_q - AW'(1);
					end else begin
						rd_addr_q <= rd_addr_q + AW'(1);
					end
				end
				S_DRAIN: begin
					if (op_q == pli_pkg::OP_INSERT) begin
						state_q <= S_PUT;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_PUT: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						rsp_status_q  <= res_status_q;
						rsp_removed_q <= res_removed_q;
						rsp_length_q  <= cnt_new_x[pli_pkg::LEN_W-1:0];
						count_q       <= cnt_new_x[CW-1:0];
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/pli_check.sv -----
module pli_check #(
	parameter int unsigned CAPACITY = pli_pkg::CAPACITY_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [pli_pkg::STATUS_W-1:0] rsp_status,
	input logic [pli_pkg::VAL_W-1:0]    rsp_removed,
	input logic [pli_pkg::LEN_W-1:0]    rsp_length
);

	localparam logic [pli_pkg::LEN_W-1:0] CAP_LEN = pli_pkg::LEN_W'(CAPACITY);

	// a stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_removed) && $stable(rsp_length))
		else $error("rsp beat changed while stalled");

	// one item in work at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// failed operations remove nothing
	a_fail_removed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != pli_pkg::ST_DONE) |-> rsp_removed == pli_pkg::NONE_REMOVED)
		else $error("removed byte on failed operation");

	// full only when the list is at capacity
	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == pli_pkg::ST_FULL) |-> rsp_length == CAP_LEN)
		else $error("full status below capacity");

	// length never beyond capacity
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (CAPACITY > 127) || (32'(rsp_length) <= CAPACITY))
		else $error("length above capacity");

endmodule

bind positional_list_insert_delete pli_check #(
	.CAPACITY (CAPACITY)
) u_pli_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_status  (rsp.status),
	.rsp_removed (rsp.removed),
	.rsp_length  (rsp.length)
);

// ----- tb/positional_list_insert_delete_test.sv -----
`timescale 1ns / 100ps

module positional_list_insert_delete_test;

	localparam int LIST_CAP = pli_pkg::CAPACITY_DEF;
	localparam int RANDOM_OPS = 2000;
	localparam int MAX_IDLE = 13;
	localparam int REPORT_LIMIT = 10;

	typedef struct {
		logic [pli_pkg::OP_W-1:0]  op;
		logic [pli_pkg::POS_W-1:0] pos;
		logic [pli_pkg::VAL_W-1:0] val;
	} list_op_t;

	typedef struct packed {
		pli_pkg::status_t            status;
		logic [pli_pkg::VAL_W-1:0]   removed;
		logic [pli_pkg::LEN_W-1:0]   length;
	} list_result_t;

	logic clk = 1'b0;
	logic arst_n;

	pli_req_if req_ch ();
	pli_rsp_if rsp_ch ();

	positional_list_insert_delete #(
		.CAPACITY(LIST_CAP)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always #5 clk = ~clk;

	// operations waiting to be sent, and results still owed by the block
	list_op_t     pending_ops[$];
	list_result_t owed_results[$];
	int           fail_count = 0;

	// shadow of the list contents for prediction
	logic [pli_pkg::VAL_W-1:0] list_bytes [LIST_CAP];
	int                        list_len;

	// length seen by the stimulus generator as it queues operations
	int gen_len = 0;

	task automatic report_fail(string what);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("%s", what);
	endtask

	// apply one operation to the shadow list and give the result it yields
	function automatic list_result_t apply_list_op(logic [pli_pkg::OP_W-1:0] op,
			logic [pli_pkg::POS_W-1:0] pos, logic [pli_pkg::VAL_W-1:0] val);
		list_result_t res;
		int p;
		p = int'(pos);
		res.status = pli_pkg::ST_DONE;
		res.removed = pli_pkg::NONE_REMOVED;
		if (op == pli_pkg::OP_INSERT) begin
			if (p < 1 || p > list_len + 1)
				res.status = pli_pkg::ST_BAD_POS;
			else if (list_len >= LIST_CAP)
				res.status = pli_pkg::ST_FULL;
			else begin
				// open a gap at the position, later elements move back
				for (int i = list_len; i >= p; i--)
					list_bytes[i] = list_bytes[i - 1];
				list_bytes[p - 1] = val;
				list_len++;
			end
		end else begin
			if (p < 1 || p > list_len)
				res.status = pli_pkg::ST_BAD_POS;
			else begin
				// take the element out and close the gap
				res.removed = list_bytes[p - 1];
				for (int i = p; i < list_len; i++)
					list_bytes[i - 1] = list_bytes[i];
				list_len--;
			end
		end
		res.length = list_len[pli_pkg::LEN_W-1:0];
		return res;
	endfunction

	// queue an operation and track the length it leaves behind
	task automatic add_op(logic [pli_pkg::OP_W-1:0] op, int pos,
			logic [pli_pkg::VAL_W-1:0] val);
		list_op_t item;
		item.op = op;
		item.pos = pos[pli_pkg::POS_W-1:0];
		item.val = val;
		pending_ops.push_back(item);
		if (op == pli_pkg::OP_INSERT) begin
			if (pos >= 1 && pos <= gen_len + 1 && gen_len < LIST_CAP)
				gen_len++;
		end else if (pos >= 1 && pos <= gen_len)
			gen_len--;
	endtask

	// position in range for the operation, or just outside it, or far out
	function automatic int pick_position(logic [pli_pkg::OP_W-1:0] op, bit in_range,
			int len);
		int upper;
		upper = (op == pli_pkg::OP_INSERT) ? len + 1 : len;
		if (in_range && upper >= 1)
			return $urandom_range(1, upper);
		case ($urandom_range(0, 3))
			0: begin
				return 0;
			end
			1: begin
				return upper + 1;
			end
			default: begin
				return $urandom_range(upper + 1, (1 << pli_pkg::POS_W) - 1);
			end
		endcase
	endfunction

	// request driver
	list_op_t next_op;
	int       gap_left;
	bit       req_burst = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.operation <= pli_pkg::OP_INSERT;
			req_ch.position <= '0;
			req_ch.value <= '0;
			gap_left = 0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (gap_left > 0) begin
				gap_left--;
				req_ch.valid <= 1'b0;
			end else if (pending_ops.size() != 0) begin
				next_op = pending_ops.pop_front();
				req_ch.operation <= next_op.op;
				req_ch.position <= next_op.pos;
				req_ch.value <= next_op.val;
				req_ch.valid <= 1'b1;
				if ($urandom_range(0, 39) == 0)
					req_burst = !req_burst;
				gap_left = req_burst ? 0 : $urandom_range(0, MAX_IDLE);
			end else
				req_ch.valid <= 1'b0;
		end
	end

	// result monitor, predictor and response back-pressure
	list_result_t got, want;
	int           stall_left;
	bit           rsp_burst = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left = 0;
			list_len = 0;
		end else begin
			// check a result beat against the oldest owed result
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.status = pli_pkg::status_t'(rsp_ch.status);
				got.removed = rsp_ch.removed;
				got.length = rsp_ch.length;
				if (owed_results.size() == 0)
					report_fail($sformatf("unexpected result: status %0d removed %0d length %0d",
						rsp_ch.status, got.removed, got.length));
				else begin
					want = owed_results.pop_front();
					if (rsp_ch.status !== want.status)
						report_fail($sformatf("status mismatch: expected %s actual %0d",
							want.status.name(), rsp_ch.status));
					if (got.removed !== want.removed)
						report_fail($sformatf("removed mismatch: expected %0d actual %0d",
							want.removed, got.removed));
					if (got.length !== want.length)
						report_fail($sformatf("length mismatch: expected %0d actual %0d",
							want.length, got.length));
				end
				if ($urandom_range(0, 39) == 0)
					rsp_burst = !rsp_burst;
				stall_left = rsp_burst ? 0 : $urandom_range(0, MAX_IDLE);
			end
			// predict for an accepted request beat
			if (req_ch.valid && req_ch.ready)
				owed_results.push_back(apply_list_op(req_ch.operation, req_ch.position,
					req_ch.value));
			// ready for the next result beat
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else
				rsp_ch.ready <= 1'b1;
		end
	end

	// stimulus, reset and end of run
	initial begin
		bit                        filling;
		logic [pli_pkg::OP_W-1:0]  op;
		int                        pos;
		bit                        in_range;

		req_ch.valid = 1'b0;
		req_ch.operation = pli_pkg::OP_INSERT;
		req_ch.position = '0;
		req_ch.value = '0;
		rsp_ch.ready = 1'b0;
		arst_n = 1'b0;

		// empty list corner cases
		add_op(pli_pkg::OP_INSERT, 0, 8'h11);
		add_op(pli_pkg::OP_DELETE, 1, 8'h22);
		add_op(pli_pkg::OP_DELETE, 0, 8'hFF);
		add_op(pli_pkg::OP_INSERT, 2, 8'h33);
		// inserts at the end, the front and the middle
		add_op(pli_pkg::OP_INSERT, 1, 8'h00);
		add_op(pli_pkg::OP_INSERT, 2, 8'hFF);
		add_op(pli_pkg::OP_INSERT, 1, 8'h5A);
		add_op(pli_pkg::OP_INSERT, 2, 8'hA5);
		// positions past the end
		add_op(pli_pkg::OP_INSERT, 127, 8'h01);
		add_op(pli_pkg::OP_INSERT, 6, 8'h02);
		add_op(pli_pkg::OP_DELETE, 5, 8'h03);
		add_op(pli_pkg::OP_DELETE, 127, 8'h04);
		// deletes at the end, the front and the middle
		add_op(pli_pkg::OP_DELETE, 4, 8'h00);
		add_op(pli_pkg::OP_DELETE, 1, 8'hFF);
		add_op(pli_pkg::OP_INSERT, 2, 8'h80);
		add_op(pli_pkg::OP_DELETE, 2, 8'h7F);
		add_op(pli_pkg::OP_DELETE, 2, 8'h00);
		add_op(pli_pkg::OP_DELETE, 1, 8'h00);
		add_op(pli_pkg::OP_DELETE, 1, 8'h00);

		// random part: fill towards full, linger there, drain to empty, repeat
		filling = 1'b1;
		for (int n = 0; n < RANDOM_OPS; n++) begin
			if (filling && gen_len == LIST_CAP && $urandom_range(0, 7) == 0)
				filling = 1'b0;
			else if (!filling && gen_len == 0 && $urandom_range(0, 7) == 0)
				filling = 1'b1;
			else if ($urandom_range(0, 79) == 0)
				filling = !filling;
			if ($urandom_range(0, 9) < 8)
				op = filling ? pli_pkg::OP_INSERT : pli_pkg::OP_DELETE;
			else
				op = filling ? pli_pkg::OP_DELETE : pli_pkg::OP_INSERT;
			in_range = ($urandom_range(0, 9) != 0);
			pos = pick_position(op, in_range, gen_len);
			add_op(op, pos, 8'($urandom_range(0, 255)));
		end

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// all requests out, then every owed result back
		do
			@(negedge clk);
		while (pending_ops.size() != 0 || req_ch.valid);
		while (owed_results.size() != 0)
			@(negedge clk);
		repeat (LIST_CAP + 8) @(negedge clk);

		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
